// File: design/ktdt_pkg.sv
// ----------------------------------------------------------------------------
// ktdt_pkg
// Shared constants, types and text helper for the keyed deadline timer table.
// ----------------------------------------------------------------------------
package ktdt_pkg;

   localparam int SLOTS       = 4;
   localparam int KEY_CHARS   = 8;
   localparam int LABEL_CHARS = 8;
   localparam int ROOM_CAP    = 4;

   localparam int IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int BUF_IDX_W = (ROOM_CAP > 1) ? $clog2(ROOM_CAP) : 1;
   localparam int NCNT_W    = $clog2(ROOM_CAP + 1);

   localparam logic [63:0] TIME_ONES = '1;

   localparam logic [2:0] KIND_SET     = 3'd0;
   localparam logic [2:0] KIND_TICK    = 3'd1;
   localparam logic [2:0] KIND_READ    = 3'd2;
   localparam logic [2:0] KIND_RELEASE = 3'd3;
   localparam logic [2:0] KIND_TAKE    = 3'd4;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_INVALID = 2'd1;
   localparam logic [1:0] STATUS_FULL    = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_APPLY,
      ST_SCHED,
      ST_EMIT
   } ktdt_state_type;

   typedef struct packed {
      logic capture;
      logic scan;
      logic apply;
      logic sched;
      logic emit_step;
   } ktdt_cmd_type;

   typedef struct packed {
      logic kind_set;
      logic idx_end;
      logic emit_last;
   } ktdt_sts_type;

   typedef struct packed {
      logic [63:0] text;
      logic        ok;
   } ktdt_text_type;

   // text ends at first zero byte; bytes past the end are cleared
   function automatic ktdt_text_type canon_text(input logic [63:0] t,
                                                input logic [3:0] limit);
      ktdt_text_type res;
      logic          done;
      logic          good;
      logic [3:0]    len;
      logic [63:0]   mask;
      logic [7:0]    b;
      done = 1'b0;
      good = 1'b1;
      len  = 4'd0;
      mask = '0;
      for (int i = 0; i < 8; i++) begin
         b = t[8*i +: 8];
         if (!done) begin
            if (b == 8'd0) begin
               done = 1'b1;
            end else begin
               if (b < 8'd32 || b > 8'd126) good = 1'b0;
               len = len + 4'd1;
               mask[8*i +: 8] = 8'hFF;
            end
         end
      end
      res.text = t & mask;
      res.ok   = good && (len >= 4'd1) && (len <= limit);
      return res;
   endfunction

endpackage

// File: design/keyed_deadline_timer_table.sv
// ----------------------------------------------------------------------------
// keyed_deadline_timer_table
// Timer slot table with set, tick, read, release and changed-flag commands.
//
//   channel   direction  tdata / tuser / tlast
//   req_      in         owner, key, label, due, now, freed, room / kind / -
//   rsp_      out        status .. changed / - / last result of the item
//
// one item at a time: capture, a scan over the slots, an update step for set,
// a deadline pass over the slots, then one result per cycle while rsp_tready
// is high (one per posted notice, then the closing one). reset is synchronous
// and empties the table. a stalled result holds until taken; no new item is
// taken until then.
// ----------------------------------------------------------------------------
module keyed_deadline_timer_table
   import ktdt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // owner_id[31:0], key_text[95:32], label_text[159:96], due_time[223:160],
   // now_time[287:224], notices_freed[288], post_room[291:289], zero pad
   input  logic [295:0] req_tdata,
   // kind[2:0]
   input  logic [2:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status[1:0], notice_valid[2], notice_owner[34:3], notice_label[98:35],
   // found[99], found_due[163:100], found_label[227:164], found_blocked[228],
   // next_deadline[292:229], changed_out[293], zero pad
   output logic [295:0] rsp_tdata,
   output logic         rsp_tlast
);

   ktdt_cmd_type cmd;
   ktdt_sts_type sts;

   logic [1:0]  status;
   logic        notice_valid;
   logic [31:0] notice_owner;
   logic [63:0] notice_label;
   logic        found;
   logic [63:0] found_due;
   logic [63:0] found_label;
   logic        found_blocked;
   logic [63:0] next_deadline;
   logic        changed_out;

   ktdt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   ktdt_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .in_kind           (req_tuser),
      .in_owner_id       (req_tdata[31:0]),
      .in_key_text       (req_tdata[95:32]),
      .in_label_text     (req_tdata[159:96]),
      .in_due_time       (req_tdata[223:160]),
      .in_now_time       (req_tdata[287:224]),
      .in_notices_freed  (req_tdata[288]),
      .in_post_room      (req_tdata[291:289]),
      .out_status        (status),
      .out_notice_valid  (notice_valid),
      .out_notice_owner  (notice_owner),
      .out_notice_label  (notice_label),
      .out_found         (found),
      .out_found_due     (found_due),
      .out_found_label   (found_label),
      .out_found_blocked (found_blocked),
      .out_next_deadline (next_deadline),
      .out_changed       (changed_out),
      .out_last          (rsp_tlast)
   );

   assign rsp_tdata = {2'b00, changed_out, next_deadline, found_blocked, found_label,
                       found_due, found, notice_label, notice_owner, notice_valid, status};

endmodule

// File: design/ktdt_ctrl.sv
// ----------------------------------------------------------------------------
// ktdt_ctrl
// Sequencer: capture, slot scan, set update, deadline pass, result delivery.
// ----------------------------------------------------------------------------
module ktdt_ctrl
   import ktdt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  ktdt_sts_type sts,
   output ktdt_cmd_type cmd
);

   ktdt_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (sts.idx_end) state_in = sts.kind_set ? ST_APPLY : ST_SCHED;
         end
         ST_APPLY: begin
            state_in = ST_SCHED;
         end
         ST_SCHED: begin
            if (sts.idx_end) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_tready && sts.emit_last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready    = (state_ff == ST_IDLE);
      rsp_tvalid    = (state_ff == ST_EMIT);
      cmd.capture   = (state_ff == ST_IDLE) && req_tvalid;
      cmd.scan      = (state_ff == ST_SCAN);
      cmd.apply     = (state_ff == ST_APPLY);
      cmd.sched     = (state_ff == ST_SCHED);
      cmd.emit_step = (state_ff == ST_EMIT) && rsp_tready && !sts.emit_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: design/ktdt_dp.sv
// ----------------------------------------------------------------------------
// ktdt_dp
// Slot table, item registers, notice buffer and deadline tracking.
// ----------------------------------------------------------------------------
module ktdt_dp
   import ktdt_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  ktdt_cmd_type  cmd,
   output ktdt_sts_type  sts,
   input  logic [2:0]    in_kind,
   input  logic [31:0]   in_owner_id,
   input  logic [63:0]   in_key_text,
   input  logic [63:0]   in_label_text,
   input  logic [63:0]   in_due_time,
   input  logic [63:0]   in_now_time,
   input  logic          in_notices_freed,
   input  logic [2:0]    in_post_room,
   output logic [1:0]    out_status,
   output logic          out_notice_valid,
   output logic [31:0]   out_notice_owner,
   output logic [63:0]   out_notice_label,
   output logic          out_found,
   output logic [63:0]   out_found_due,
   output logic [63:0]   out_found_label,
   output logic          out_found_blocked,
   output logic [63:0]   out_next_deadline,
   output logic          out_changed,
   output logic          out_last
);

   logic [31:0] slot_owner_ff [SLOTS], slot_owner_in [SLOTS];
   logic [63:0] slot_key_ff   [SLOTS], slot_key_in   [SLOTS];
   logic [63:0] slot_label_ff [SLOTS], slot_label_in [SLOTS];
   logic [63:0] slot_due_ff   [SLOTS], slot_due_in   [SLOTS];
   logic        slot_blk_ff   [SLOTS], slot_blk_in   [SLOTS];

   logic [31:0] buf_owner_ff [ROOM_CAP], buf_owner_in [ROOM_CAP];
   logic [63:0] buf_label_ff [ROOM_CAP], buf_label_in [ROOM_CAP];

   logic [63:0] earliest_ff, earliest_in;
   logic [63:0] min_ff, min_in;
   logic        changed_ff, changed_in;
   logic        take_flag_ff, take_flag_in;
   logic        take_val_ff, take_val_in;

   logic [2:0]  kind_ff, kind_in;
   logic [31:0] owner_ff, owner_in;
   logic [63:0] key_ff, key_in;
   logic [63:0] label_ff, label_in;
   logic        kok_ff, kok_in;
   logic        lok_ff, lok_in;
   logic [63:0] due_ff, due_in;
   logic [63:0] now_ff, now_in;
   logic        freed_ff, freed_in;
   logic [2:0]  room_ff, room_in;
   logic        gate_ff, gate_in;

   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [IDX_W-1:0]  sel_ff, sel_in;
   logic              sel_found_ff, sel_found_in;
   logic              match_ff, match_in;
   logic              same_ff, same_in;
   logic [1:0]        status_ff, status_in;
   logic              found_ff, found_in;
   logic [63:0]       fdue_ff, fdue_in;
   logic [63:0]       flab_ff, flab_in;
   logic              fblk_ff, fblk_in;
   logic [NCNT_W-1:0] ncount_ff, ncount_in;
   logic [NCNT_W-1:0] emit_idx_ff, emit_idx_in;

   ktdt_text_type key_c, label_c;
   logic [31:0]   s_own;
   logic [63:0]   s_key, s_lab, s_due;
   logic          s_blk, s_live, s_match;
   logic          idx_end;
   logic [63:0]   cur_min;
   logic          notice_on;

   assign key_c   = canon_text(in_key_text, 4'(KEY_CHARS));
   assign label_c = canon_text(in_label_text, 4'(LABEL_CHARS));

   assign s_own   = slot_owner_ff[idx_ff];
   assign s_key   = slot_key_ff[idx_ff];
   assign s_lab   = slot_label_ff[idx_ff];
   assign s_due   = slot_due_ff[idx_ff];
   assign s_blk   = slot_blk_ff[idx_ff];
   assign s_live  = (s_due != 64'd0);
   assign s_match = s_live && (s_own == owner_ff) && (s_key == key_ff);
   assign idx_end = (idx_ff == IDX_W'(SLOTS - 1));
   assign cur_min = (idx_ff == '0) ? TIME_ONES : min_ff;

   assign sts.kind_set  = (kind_ff == KIND_SET);
   assign sts.idx_end   = idx_end;
   assign sts.emit_last = (emit_idx_ff == ncount_ff);

   always_comb begin
      slot_owner_in = slot_owner_ff;
      slot_key_in   = slot_key_ff;
      slot_label_in = slot_label_ff;
      slot_due_in   = slot_due_ff;
      slot_blk_in   = slot_blk_ff;
      buf_owner_in  = buf_owner_ff;
      buf_label_in  = buf_label_ff;
      earliest_in   = earliest_ff;
      min_in        = min_ff;
      changed_in    = changed_ff;
      take_flag_in  = take_flag_ff;
      take_val_in   = take_val_ff;
      kind_in       = kind_ff;
      owner_in      = owner_ff;
      key_in        = key_ff;
      label_in      = label_ff;
      kok_in        = kok_ff;
      lok_in        = lok_ff;
      due_in        = due_ff;
      now_in        = now_ff;
      freed_in      = freed_ff;
      room_in       = room_ff;
      gate_in       = gate_ff;
      idx_in        = idx_ff;
      sel_in        = sel_ff;
      sel_found_in  = sel_found_ff;
      match_in      = match_ff;
      same_in       = same_ff;
      status_in     = status_ff;
      found_in      = found_ff;
      fdue_in       = fdue_ff;
      flab_in       = flab_ff;
      fblk_in       = fblk_ff;
      ncount_in     = ncount_ff;
      emit_idx_in   = emit_idx_ff;

      if (cmd.capture) begin
         kind_in      = in_kind;
         owner_in     = in_owner_id;
         key_in       = key_c.text;
         kok_in       = key_c.ok;
         label_in     = label_c.text;
         lok_in       = label_c.ok;
         due_in       = in_due_time;
         now_in       = in_now_time;
         freed_in     = in_notices_freed;
         room_in      = (in_post_room > 3'(ROOM_CAP)) ? 3'(ROOM_CAP) : in_post_room;
         gate_in      = in_notices_freed || (in_now_time >= earliest_ff);
         idx_in       = '0;
         sel_in       = '0;
         sel_found_in = 1'b0;
         match_in     = 1'b0;
         same_in      = 1'b0;
         status_in    = STATUS_OK;
         found_in     = 1'b0;
         fdue_in      = '0;
         flab_in      = '0;
         fblk_in      = 1'b0;
         ncount_in    = '0;
         emit_idx_in  = '0;
         take_flag_in = (in_kind == KIND_TAKE);
         if (in_kind == KIND_TAKE) begin
            take_val_in = changed_ff;
            changed_in  = 1'b0;
         end
      end

      if (cmd.scan) begin
         unique case (kind_ff)
            KIND_SET: begin
               if (!match_ff) begin
                  if (s_match) begin
                     sel_in   = idx_ff;
                     match_in = 1'b1;
                     same_in  = (s_due == due_ff) && (s_lab == label_ff);
                  end else if (!s_live && !sel_found_ff) begin
                     sel_in       = idx_ff;
                     sel_found_in = 1'b1;
                  end
               end
            end
            KIND_TICK: begin
               if (gate_ff && s_live && (now_ff >= s_due) && !(s_blk && !freed_ff)) begin
                  if (room_ff != 3'd0) begin
                     room_in = room_ff - 3'd1;
                     buf_owner_in[ncount_ff[BUF_IDX_W-1:0]] = s_own;
                     buf_label_in[ncount_ff[BUF_IDX_W-1:0]] = s_lab;
                     ncount_in = ncount_ff + NCNT_W'(1);
                     slot_owner_in[idx_ff] = '0;
                     slot_key_in[idx_ff]   = '0;
                     slot_label_in[idx_ff] = '0;
                     slot_due_in[idx_ff]   = '0;
                     slot_blk_in[idx_ff]   = 1'b0;
                     changed_in = 1'b1;
                  end else if (!s_blk) begin
                     slot_blk_in[idx_ff] = 1'b1;
                     changed_in = 1'b1;
                  end
               end
            end
            KIND_READ: begin
               if ((owner_ff != 32'd0) && s_match && !found_ff) begin
                  found_in = 1'b1;
                  fdue_in  = s_due;
                  flab_in  = s_lab;
                  fblk_in  = s_blk;
               end
            end
            KIND_RELEASE: begin
               if ((owner_ff != 32'd0) && (s_own == owner_ff)) begin
                  slot_owner_in[idx_ff] = '0;
                  slot_key_in[idx_ff]   = '0;
                  slot_label_in[idx_ff] = '0;
                  slot_due_in[idx_ff]   = '0;
                  slot_blk_in[idx_ff]   = 1'b0;
                  changed_in = 1'b1;
               end
            end
            default: ;
         endcase
         idx_in = idx_end ? '0 : idx_ff + IDX_W'(1);
      end

      if (cmd.apply) begin
         if ((owner_ff == 32'd0) || !kok_ff || !lok_ff || (due_ff == TIME_ONES)) begin
            status_in = STATUS_INVALID;
         end else if (due_ff == 64'd0) begin
            if (match_ff) begin
               slot_owner_in[sel_ff] = '0;
               slot_key_in[sel_ff]   = '0;
               slot_label_in[sel_ff] = '0;
               slot_due_in[sel_ff]   = '0;
               slot_blk_in[sel_ff]   = 1'b0;
               changed_in = 1'b1;
            end
         end else if (!match_ff && !sel_found_ff) begin
            status_in = STATUS_FULL;
         end else if (!(match_ff && same_ff)) begin
            slot_owner_in[sel_ff] = owner_ff;
            slot_key_in[sel_ff]   = key_ff;
            slot_label_in[sel_ff] = label_ff;
            slot_due_in[sel_ff]   = due_ff;
            slot_blk_in[sel_ff]   = 1'b0;
            changed_in = 1'b1;
         end
      end

      if (cmd.sched) begin
         // running minimum over live, unblocked slots
         if (s_live && !s_blk && (s_due < cur_min)) begin
            min_in = s_due;
         end else begin
            min_in = cur_min;
         end
         if (idx_end) earliest_in = min_in;
         idx_in = idx_end ? '0 : idx_ff + IDX_W'(1);
      end

      if (cmd.emit_step) begin
         emit_idx_in = emit_idx_ff + NCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            slot_owner_ff[i] <= '0;
            slot_key_ff[i]   <= '0;
            slot_label_ff[i] <= '0;
            slot_due_ff[i]   <= '0;
            slot_blk_ff[i]   <= 1'b0;
         end
         earliest_ff  <= TIME_ONES;
         changed_ff   <= 1'b0;
         take_flag_ff <= 1'b0;
         idx_ff       <= '0;
         ncount_ff    <= '0;
         emit_idx_ff  <= '0;
      end else begin
         slot_owner_ff <= slot_owner_in;
         slot_key_ff   <= slot_key_in;
         slot_label_ff <= slot_label_in;
         slot_due_ff   <= slot_due_in;
         slot_blk_ff   <= slot_blk_in;
         earliest_ff   <= earliest_in;
         changed_ff    <= changed_in;
         take_flag_ff  <= take_flag_in;
         idx_ff        <= idx_in;
         ncount_ff     <= ncount_in;
         emit_idx_ff   <= emit_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_owner_ff <= buf_owner_in;
      buf_label_ff <= buf_label_in;
      min_ff       <= min_in;
      take_val_ff  <= take_val_in;
      kind_ff      <= kind_in;
      owner_ff     <= owner_in;
      key_ff       <= key_in;
      label_ff     <= label_in;
      kok_ff       <= kok_in;
      lok_ff       <= lok_in;
      due_ff       <= due_in;
      now_ff       <= now_in;
      freed_ff     <= freed_in;
      room_ff      <= room_in;
      gate_ff      <= gate_in;
      sel_ff       <= sel_in;
      sel_found_ff <= sel_found_in;
      match_ff     <= match_in;
      same_ff      <= same_in;
      status_ff    <= status_in;
      found_ff     <= found_in;
      fdue_ff      <= fdue_in;
      flab_ff      <= flab_in;
      fblk_ff      <= fblk_in;
   end

   // notices first, then the closing transaction
   assign notice_on         = (emit_idx_ff < ncount_ff);
   assign out_notice_valid  = notice_on;
   assign out_notice_owner  = notice_on ? buf_owner_ff[emit_idx_ff[BUF_IDX_W-1:0]] : '0;
   assign out_notice_label  = notice_on ? buf_label_ff[emit_idx_ff[BUF_IDX_W-1:0]] : '0;
   assign out_status        = status_ff;
   assign out_found         = found_ff;
   assign out_found_due     = fdue_ff;
   assign out_found_label   = flab_ff;
   assign out_found_blocked = fblk_ff;
   assign out_next_deadline = earliest_ff;
   assign out_changed       = take_flag_ff ? take_val_ff : changed_ff;
   assign out_last          = !notice_on;

endmodule
